/* src/ucer_pkg.sv */
// Shared types, codes and defaults for the USB control endpoint responder.
// Depends on nothing; every other file in src imports it.
package ucer_pkg;

   // Endpoint handshake codes
   typedef enum logic [1:0] {
      HS_DISABLED = 2'd0,
      HS_STALL    = 2'd1,
      HS_NAK      = 2'd2,
      HS_VALID    = 2'd3
   } hs_type;

   typedef enum logic [1:0] {
      KIND_SETUP = 2'd0,
      KIND_OUT   = 2'd1,
      KIND_IN    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CS_SETUP         = 3'd0,
      CS_DATA_IN       = 3'd1,
      CS_LAST_DATA_IN  = 3'd2,
      CS_LAST_DATA_OUT = 3'd3,
      CS_STATUS_IN     = 3'd4,
      CS_STATUS_OUT    = 3'd5
   } ctrl_stage_type;

   typedef enum logic [1:0] {
      DS_DEFAULT    = 2'd0,
      DS_ADDRESS    = 2'd1,
      DS_CONFIGURE  = 2'd2,
      DS_CONFIGURED = 2'd3
   } dev_stage_type;

   typedef enum logic [3:0] {
      LOAD_NONE         = 4'd0,
      LOAD_DEVICE       = 4'd1,
      LOAD_CONFIG_SHORT = 4'd2,
      LOAD_CONFIG_FIRST = 4'd3,
      LOAD_CONFIG_REST  = 4'd4,
      LOAD_LANGID       = 4'd5,
      LOAD_VENDOR       = 4'd6,
      LOAD_PRODUCT      = 4'd7,
      LOAD_SERIAL       = 4'd8
   } load_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_PACKET_SIZE   = 3'd0,
      CSR_CONFIG_LENGTH = 3'd1,
      CSR_LANGID_LENGTH = 3'd2,
      CSR_VENDOR_LENGTH = 3'd3,
      CSR_PRODUCT_LENGTH = 3'd4,
      CSR_SERIAL_LENGTH = 3'd5
   } csr_index_type;

   localparam int unsigned CsrDataWidth = 8;
   localparam int unsigned QueueDepthDefault = 2;

   // Standard request and descriptor codes
   localparam logic [7:0] ReqSetAddress    = 8'h05;
   localparam logic [7:0] ReqSetConfig     = 8'h09;
   localparam logic [7:0] ReqGetDescriptor = 8'h06;
   localparam logic [7:0] ReqSetLineCoding = 8'h20;
   localparam logic [7:0] ClassMask        = 8'h21;
   localparam logic [7:0] DescDevice       = 8'h01;
   localparam logic [7:0] DescConfig       = 8'h02;
   localparam logic [7:0] DescString       = 8'h03;
   localparam logic [7:0] DescEndpoint     = 8'h05;
   localparam logic [7:0] DeviceDescLength = 8'd18;
   localparam logic [7:0] ConfigShortLength = 8'd9;

   // Reset values of the configuration registers
   localparam logic [6:0] PacketSizeReset    = 7'd64;
   localparam logic [7:0] ConfigLengthReset  = 8'd67;
   localparam logic [7:0] LangidLengthReset  = 8'd4;
   localparam logic [7:0] VendorLengthReset  = 8'd38;
   localparam logic [7:0] ProductLengthReset = 8'd50;
   localparam logic [7:0] SerialLengthReset  = 8'd26;

   typedef struct packed {
      logic [6:0] packet_size;
      logic [7:0] config_total_length;
      logic [7:0] langid_length;
      logic [7:0] vendor_length;
      logic [7:0] product_length;
      logic [7:0] serial_length;
   } cfg_type;

   // Classified event, as carried from the front end to the back end
   typedef struct packed {
      logic        err;
      kind_type    kind;
      logic        ep0;
      logic        ep1_arm;
      logic [1:0]  rx_status;
      logic [1:0]  tx_status;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] value_word;
      logic [15:0] length_word;
   } evt_type;

   typedef struct packed {
      logic       error;
      kind_type   transaction_kind;
      hs_type     ep0_rx_new;
      hs_type     ep0_tx_new;
      logic       tx_count_write;
      logic [7:0] tx_count;
      load_type   load_source;
      logic       rx_count_arm;
      logic       address_write;
      logic [6:0] device_address;
      logic       ep1_tx_arm;
   } rsp_type;

endpackage

/* src/usb_control_endpoint_responder.sv */
// Top level of the USB control endpoint responder: config registers,
// front end, event queue and back end. Depends on ucer_pkg and the ucer_* modules.
//
// Usage: each completed USB transfer is presented on the req_ channel as one
// transaction (endpoint, flags, prior handshakes, setup packet fields). The
// block answers every request with exactly one rsp_ transaction carrying the
// decoded kind, the new endpoint zero handshakes, byte count, descriptor
// chunk select, address write and endpoint one re-arm.
// Path: an accepted request is written into the event queue, then popped into
// the result register, which raises rsp_valid, once the back end is not stalled.
// Throughput: one transaction per cycle while rsp_stall does not hold the result
// register; the back end updates its state as each transaction is popped.
// Stall: when rsp_stall holds the result register, the back end stops popping
// and the queue (QueueDepth entries) absorbs requests; req_stall rises only
// when the queue is full. rsp_valid is registered, with no combinational path from rsp_stall.
// Reset: synchronous; clears the queue, device stage (default), control stage
// (setup), the saved wValue, and loads register defaults (packet size 64,
// config length 67, string lengths 4/38/50/26).
// Configuration: csr_write/csr_index/csr_data, write only while idle.
module usb_control_endpoint_responder #(
   parameter int unsigned QueueDepth = ucer_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write,
   input  logic [2:0]                        csr_index,
   input  logic [ucer_pkg::CsrDataWidth-1:0] csr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_ep_index,
   input  logic                              req_dir_flag,
   input  logic                              req_setup_flag,
   input  logic                              req_rx_done_flag,
   input  logic                              req_tx_done_flag,
   input  logic [1:0]                        req_rx_status,
   input  logic [1:0]                        req_tx_status,
   input  logic [7:0]                        req_request_type,
   input  logic [7:0]                        req_request_code,
   input  logic [15:0]                       req_value_word,
   input  logic [15:0]                       req_length_word,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_error,
   output logic [1:0]                        rsp_transaction_kind,
   output logic [1:0]                        rsp_ep0_rx_new,
   output logic [1:0]                        rsp_ep0_tx_new,
   output logic                              rsp_tx_count_write,
   output logic [7:0]                        rsp_tx_count,
   output logic [3:0]                        rsp_load_source,
   output logic                              rsp_rx_count_arm,
   output logic                              rsp_address_write,
   output logic [6:0]                        rsp_device_address,
   output logic                              rsp_ep1_tx_arm
);
   import ucer_pkg::*;

   cfg_type cfg_ff, cfg_in;
   evt_type front_evt;
   evt_type queue_evt;
   logic    queue_valid;
   logic    back_stall;
   rsp_type rsp;

   // Configuration registers: hold until written, drop writes to unused indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PACKET_SIZE:    cfg_in.packet_size         = csr_data[6:0];
            CSR_CONFIG_LENGTH:  cfg_in.config_total_length = csr_data;
            CSR_LANGID_LENGTH:  cfg_in.langid_length       = csr_data;
            CSR_VENDOR_LENGTH:  cfg_in.vendor_length       = csr_data;
            CSR_PRODUCT_LENGTH: cfg_in.product_length      = csr_data;
            CSR_SERIAL_LENGTH:  cfg_in.serial_length       = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_size         <= PacketSizeReset;
         cfg_ff.config_total_length <= ConfigLengthReset;
         cfg_ff.langid_length       <= LangidLengthReset;
         cfg_ff.vendor_length       <= VendorLengthReset;
         cfg_ff.product_length      <= ProductLengthReset;
         cfg_ff.serial_length       <= SerialLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify the incoming transaction; no state is needed for that
   ucer_front u_front (
      .ep_index     (req_ep_index),
      .dir_flag     (req_dir_flag),
      .setup_flag   (req_setup_flag),
      .rx_done_flag (req_rx_done_flag),
      .tx_done_flag (req_tx_done_flag),
      .rx_status    (req_rx_status),
      .tx_status    (req_tx_status),
      .request_type (req_request_type),
      .request_code (req_request_code),
      .value_word   (req_value_word),
      .length_word  (req_length_word),
      .evt          (front_evt)
   );

   // Decouple acceptance from execution
   ucer_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_evt    (front_evt),
      .out_valid (queue_valid),
      .out_stall (back_stall),
      .out_evt   (queue_evt)
   );

   // Execute against device and control stage, register the result
   ucer_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_valid (queue_valid),
      .evt_stall (back_stall),
      .evt       (queue_evt),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_error            = rsp.error;
   assign rsp_transaction_kind = rsp.transaction_kind;
   assign rsp_ep0_rx_new       = rsp.ep0_rx_new;
   assign rsp_ep0_tx_new       = rsp.ep0_tx_new;
   assign rsp_tx_count_write   = rsp.tx_count_write;
   assign rsp_tx_count         = rsp.tx_count;
   assign rsp_load_source      = rsp.load_source;
   assign rsp_rx_count_arm     = rsp.rx_count_arm;
   assign rsp_address_write    = rsp.address_write;
   assign rsp_device_address   = rsp.device_address;
   assign rsp_ep1_tx_arm       = rsp.ep1_tx_arm;

   // An error result always reports kind SETUP, with no endpoint one re-arm, address write or byte-count write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |->
         rsp_transaction_kind == KIND_SETUP && !rsp_ep1_tx_arm &&
         !rsp_address_write && !rsp_tx_count_write)
      else $error("error result carries side effects");

   // The address write comes with the status-stage handshakes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_write |->
         rsp_ep0_rx_new == HS_VALID && rsp_ep0_tx_new == HS_STALL &&
         rsp_transaction_kind == KIND_IN)
      else $error("address write outside the status stage");

   // A descriptor load always writes a byte count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_source != LOAD_NONE |-> rsp_tx_count_write)
      else $error("descriptor load without byte count");

   // Endpoint one re-arm only on an IN completion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ep1_tx_arm |-> rsp_transaction_kind == KIND_IN)
      else $error("endpoint one re-armed on a non-IN transaction");

endmodule

/* src/ucer_front.sv */
// Front end: classifies a completed-transfer event as SETUP, OUT or IN, or flags an error.
// Depends on ucer_pkg.
module ucer_front (
   input  logic [3:0]      ep_index,
   input  logic            dir_flag,
   input  logic            setup_flag,
   input  logic            rx_done_flag,
   input  logic            tx_done_flag,
   input  logic [1:0]      rx_status,
   input  logic [1:0]      tx_status,
   input  logic [7:0]      request_type,
   input  logic [7:0]      request_code,
   input  logic [15:0]     value_word,
   input  logic [15:0]     length_word,
   output ucer_pkg::evt_type evt
);
   import ucer_pkg::*;

   logic ep0;

   assign ep0 = (ep_index == 4'd0);

   always_comb begin
      evt              = '0;
      evt.ep0          = ep0;
      evt.rx_status    = rx_status;
      evt.tx_status    = tx_status;
      evt.request_type = request_type;
      evt.request_code = request_code;
      evt.value_word   = value_word;
      evt.length_word  = length_word;
      evt.kind         = KIND_SETUP;
      if (ep0) begin
         if (!dir_flag) begin
            evt.kind = KIND_IN;
         end else if (setup_flag) begin
            evt.kind = KIND_SETUP;
         end else if (rx_done_flag) begin
            evt.kind = KIND_OUT;
         end else begin
            evt.err = 1'b1;
         end
      end else begin
         if (rx_done_flag) begin
            evt.kind = KIND_OUT;
         end else if (tx_done_flag) begin
            evt.kind    = KIND_IN;
            evt.ep1_arm = (ep_index == 4'd1);
         end else begin
            evt.err = 1'b1;
         end
      end
   end

endmodule

/* src/ucer_queue.sv */
// Short event queue between front and back end.
// Depends on ucer_pkg.
module ucer_queue #(
   parameter int unsigned Depth = ucer_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  ucer_pkg::evt_type in_evt,
   output logic              out_valid,
   input  logic              out_stall,
   output ucer_pkg::evt_type out_evt
);
   import ucer_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   evt_type               slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign in_stall  = (count_ff == FullCnt);
   assign out_valid = (count_ff != '0);
   assign out_evt   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_evt;
      end
   end

endmodule

/* src/ucer_back.sv */
// Back end: control-transfer state machine and registered result.
// Depends on ucer_pkg.
module ucer_back (
   input  logic              clock,
   input  logic              reset,
   input  ucer_pkg::cfg_type cfg,
   input  logic              evt_valid,
   output logic              evt_stall,
   input  ucer_pkg::evt_type evt,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ucer_pkg::rsp_type rsp
);
   import ucer_pkg::*;

   ctrl_stage_type ctrl_ff, ctrl_in;
   dev_stage_type  dev_ff, dev_in;
   logic [15:0]    saved_ff, saved_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;
   logic           pop;

   // Descriptor decode
   logic           desc_send;
   logic           desc_stall;
   logic [7:0]     desc_count;
   load_type       desc_src;
   ctrl_stage_type desc_stage;
   logic [7:0]     desc_type;
   logic [7:0]     desc_idx;
   logic [7:0]     psize;
   logic [7:0]     rest_count;

   assign evt_stall = rsp_valid_ff && rsp_stall;
   assign pop       = evt_valid && !evt_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign desc_type  = evt.value_word[15:8];
   assign desc_idx   = evt.value_word[7:0];
   assign psize      = {1'b0, cfg.packet_size};
   assign rest_count = (cfg.config_total_length > psize) ?
                       (cfg.config_total_length - psize) : 8'd0;

   always_comb begin
      desc_send  = 1'b0;
      desc_stall = 1'b0;
      desc_count = '0;
      desc_src   = LOAD_NONE;
      desc_stage = CS_LAST_DATA_IN;
      case (desc_type)
         DescDevice: begin
            desc_send  = 1'b1;
            desc_count = DeviceDescLength;
            desc_src   = LOAD_DEVICE;
         end
         DescConfig: begin
            if (evt.length_word == 16'(ConfigShortLength)) begin
               desc_send  = 1'b1;
               desc_count = ConfigShortLength;
               desc_src   = LOAD_CONFIG_SHORT;
            end else if (evt.length_word == {8'd0, cfg.config_total_length}) begin
               desc_send = 1'b1;
               desc_src  = LOAD_CONFIG_FIRST;
               if (cfg.config_total_length <= psize) begin
                  desc_count = cfg.config_total_length;
               end else begin
                  desc_count = psize;
                  desc_stage = CS_DATA_IN;
               end
            end else begin
               desc_stall = 1'b1;
            end
         end
         DescString: begin
            desc_send = 1'b1;
            case (desc_idx)
               8'd0: begin
                  desc_count = cfg.langid_length;
                  desc_src   = LOAD_LANGID;
               end
               8'd1: begin
                  desc_count = cfg.vendor_length;
                  desc_src   = LOAD_VENDOR;
               end
               8'd2: begin
                  desc_count = cfg.product_length;
                  desc_src   = LOAD_PRODUCT;
               end
               8'd3: begin
                  desc_count = cfg.serial_length;
                  desc_src   = LOAD_SERIAL;
               end
               default: begin
                  desc_send  = 1'b0;
                  desc_stall = 1'b1;
               end
            endcase
         end
         DescEndpoint: begin
            desc_send = 1'b0;
         end
         default: begin
            desc_stall = 1'b1;
         end
      endcase
   end

   // Next state
   always_comb begin
      ctrl_in  = ctrl_ff;
      dev_in   = dev_ff;
      saved_in = saved_ff;
      if (pop && !evt.err && evt.ep0) begin
         case (evt.kind)
            KIND_SETUP: begin
               ctrl_in  = CS_SETUP;
               saved_in = evt.value_word;
               if (evt.length_word == '0) begin
                  if (evt.request_code == ReqSetAddress) begin
                     dev_in = DS_ADDRESS;
                  end else if (evt.request_code == ReqSetConfig) begin
                     dev_in = DS_CONFIGURE;
                  end
               end else if (evt.request_type[7]) begin
                  if (evt.request_code == ReqGetDescriptor && desc_send) begin
                     ctrl_in = desc_stage;
                  end
               end else if ((evt.request_type & ClassMask) != '0) begin
                  if (evt.request_code == ReqSetLineCoding) begin
                     ctrl_in = CS_LAST_DATA_OUT;
                     dev_in  = DS_CONFIGURED;
                  end
               end
            end
            KIND_OUT: begin
               if (ctrl_ff == CS_LAST_DATA_OUT) begin
                  ctrl_in = CS_STATUS_IN;
               end
            end
            KIND_IN: begin
               if (dev_ff == DS_ADDRESS) begin
                  dev_in = DS_CONFIGURE;
               end else if (ctrl_ff == CS_LAST_DATA_IN) begin
                  ctrl_in = CS_STATUS_OUT;
               end else if (ctrl_ff == CS_DATA_IN) begin
                  ctrl_in = CS_LAST_DATA_IN;
               end
            end
            default: begin
               ctrl_in = ctrl_ff;
            end
         endcase
      end
   end

   // Result
   always_comb begin
      rsp_in                  = '0;
      rsp_in.error            = evt.err;
      rsp_in.transaction_kind = evt.err ? KIND_SETUP : evt.kind;
      rsp_in.ep0_rx_new       = HS_DISABLED;
      rsp_in.ep0_tx_new       = HS_DISABLED;
      rsp_in.load_source      = LOAD_NONE;
      rsp_in.ep1_tx_arm       = evt.ep1_arm && !evt.err;
      if (evt.ep0) begin
         if (evt.err) begin
            rsp_in.ep0_rx_new = HS_NAK;
            rsp_in.ep0_tx_new = HS_NAK;
         end else begin
            case (evt.kind)
               KIND_SETUP: begin
                  rsp_in.ep0_rx_new = hs_type'(evt.rx_status);
                  rsp_in.ep0_tx_new = hs_type'(evt.tx_status);
                  if (evt.length_word == '0) begin
                     if (evt.request_code == ReqSetAddress ||
                         evt.request_code == ReqSetConfig) begin
                        rsp_in.tx_count_write = 1'b1;
                        rsp_in.ep0_tx_new     = HS_VALID;
                     end
                  end else if (evt.request_type[7]) begin
                     if (evt.request_code == ReqGetDescriptor) begin
                        if (desc_send) begin
                           rsp_in.tx_count_write = 1'b1;
                           rsp_in.tx_count       = desc_count;
                           rsp_in.load_source    = desc_src;
                           rsp_in.ep0_rx_new     = HS_STALL;
                           rsp_in.ep0_tx_new     = HS_VALID;
                        end else if (desc_stall) begin
                           rsp_in.ep0_rx_new = HS_VALID;
                           rsp_in.ep0_tx_new = HS_STALL;
                        end
                     end
                  end else if ((evt.request_type & ClassMask) != '0) begin
                     if (evt.request_code == ReqSetLineCoding) begin
                        rsp_in.ep0_rx_new   = HS_VALID;
                        rsp_in.ep0_tx_new   = HS_STALL;
                        rsp_in.rx_count_arm = 1'b1;
                     end
                  end
               end
               KIND_OUT: begin
                  rsp_in.ep0_rx_new = hs_type'(evt.rx_status);
                  rsp_in.ep0_tx_new = hs_type'(evt.tx_status);
                  if (ctrl_ff == CS_LAST_DATA_OUT) begin
                     rsp_in.ep0_rx_new     = HS_STALL;
                     rsp_in.ep0_tx_new     = HS_VALID;
                     rsp_in.tx_count_write = 1'b1;
                  end
               end
               KIND_IN: begin
                  rsp_in.ep0_rx_new = HS_NAK;
                  rsp_in.ep0_tx_new = HS_NAK;
                  if (dev_ff == DS_ADDRESS) begin
                     rsp_in.address_write  = 1'b1;
                     rsp_in.device_address = saved_ff[6:0];
                     rsp_in.rx_count_arm   = 1'b1;
                     rsp_in.ep0_rx_new     = HS_VALID;
                     rsp_in.ep0_tx_new     = HS_STALL;
                  end else if (ctrl_ff == CS_LAST_DATA_IN ||
                               ctrl_ff == CS_STATUS_IN) begin
                     rsp_in.ep0_rx_new = HS_VALID;
                     rsp_in.ep0_tx_new = HS_STALL;
                  end else if (ctrl_ff == CS_DATA_IN) begin
                     rsp_in.tx_count_write = 1'b1;
                     rsp_in.tx_count       = rest_count;
                     rsp_in.load_source    = LOAD_CONFIG_REST;
                     rsp_in.ep0_rx_new     = HS_VALID;
                     rsp_in.ep0_tx_new     = HS_VALID;
                  end
               end
               default: begin
                  rsp_in.ep0_rx_new = HS_NAK;
                  rsp_in.ep0_tx_new = HS_NAK;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= CS_SETUP;
         dev_ff       <= DS_DEFAULT;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff  <= ctrl_in;
         dev_ff   <= dev_in;
         saved_ff <= saved_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* bench/tb.sv */
// Self-checking bench for usb_control_endpoint_responder: directed and random USB transfer
// events, random handshake gaps on both channels, a predictor written from the spec.
// Depends on ucer_pkg (src/ucer_pkg.sv) and the RTL under src.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ucer_pkg::*;

   // bmRequestType values used to build setup packets
   localparam logic [7:0] ReqTypeDeviceToHost = 8'h80;
   localparam logic [7:0] ReqTypeClassIface   = 8'h21;
   localparam logic [7:0] ReqTypeStandardOut  = 8'h00;

   localparam int unsigned MaxIdle       = 16;   // longest per-transaction gap or stall
   localparam int unsigned LongHold      = 80;   // receiver hold-off for the pressure test
   localparam int unsigned QuietLimit    = 1000; // cycles without any handshake
   localparam int unsigned ItemsPerPhase = 340;
   localparam int unsigned MaxReported   = 200;

   // One completed-transfer event as it appears on the req_ channel
   typedef struct packed {
      logic [3:0]  ep_index;
      logic        dir_flag;
      logic        setup_flag;
      logic        rx_done_flag;
      logic        tx_done_flag;
      logic [1:0]  rx_status;
      logic [1:0]  tx_status;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] value_word;
      logic [15:0] length_word;
   } usb_xfer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_PACKET_SIZE;
   logic [CsrDataWidth-1:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_ep_index = '0;
   logic        req_dir_flag = 1'b0;
   logic        req_setup_flag = 1'b0;
   logic        req_rx_done_flag = 1'b0;
   logic        req_tx_done_flag = 1'b0;
   logic [1:0]  req_rx_status = '0;
   logic [1:0]  req_tx_status = '0;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_value_word = '0;
   logic [15:0] req_length_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_error;
   logic [1:0]  rsp_transaction_kind;
   logic [1:0]  rsp_ep0_rx_new;
   logic [1:0]  rsp_ep0_tx_new;
   logic        rsp_tx_count_write;
   logic [7:0]  rsp_tx_count;
   logic [3:0]  rsp_load_source;
   logic        rsp_rx_count_arm;
   logic        rsp_address_write;
   logic [6:0]  rsp_device_address;
   logic        rsp_ep1_tx_arm;

   usb_control_endpoint_responder DUT (
      .clock, .reset,
      .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_ep_index, .req_dir_flag, .req_setup_flag,
      .req_rx_done_flag, .req_tx_done_flag, .req_rx_status, .req_tx_status,
      .req_request_type, .req_request_code, .req_value_word, .req_length_word,
      .rsp_valid, .rsp_stall, .rsp_error, .rsp_transaction_kind,
      .rsp_ep0_rx_new, .rsp_ep0_tx_new, .rsp_tx_count_write, .rsp_tx_count,
      .rsp_load_source, .rsp_rx_count_arm, .rsp_address_write,
      .rsp_device_address, .rsp_ep1_tx_arm
   );

   // Mirror of the block's registers and control state, advanced once per accepted request
   cfg_type        regs;
   dev_stage_type  dev_stage;
   ctrl_stage_type ctl_stage;
   logic [15:0]    setup_value;

   rsp_type     pending_responses[$];   // predicted responses, oldest first
   int unsigned mismatch_count = 0;
   int unsigned sent_count = 0;
   bit          sender_idle_on = 1'b1;
   bit          receiver_idle_on = 1'b1;
   bit          long_hold_request = 1'b0;
   int unsigned quiet_cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic cfg_type make_regs(input logic [6:0] ps, input logic [7:0] cl,
                                         input logic [7:0] lg, input logic [7:0] vd,
                                         input logic [7:0] pr, input logic [7:0] sr);
      cfg_type c;
      c.packet_size = ps;
      c.config_total_length = cl;
      c.langid_length = lg;
      c.vendor_length = vd;
      c.product_length = pr;
      c.serial_length = sr;
      return c;
   endfunction

   // Start a data-stage chunk: byte count, descriptor select, tx valid, rx stall
   function automatic void load_chunk(inout rsp_type r, input logic [7:0] count,
                                      input load_type src);
      r.tx_count_write = 1'b1;
      r.tx_count = count;
      r.load_source = src;
      r.ep0_tx_new = HS_VALID;
      r.ep0_rx_new = HS_STALL;
   endfunction

   function automatic void stall_ep0(inout rsp_type r);
      r.ep0_rx_new = HS_VALID;
      r.ep0_tx_new = HS_STALL;
   endfunction

   // Work out the response to one transfer event and advance the mirrored state
   function automatic rsp_type predict_response(input usb_xfer_type x);
      rsp_type    r;
      logic [7:0] dtype;
      logic [7:0] didx;
      logic [7:0] ps8;
      r = '0;
      ps8 = {1'b0, regs.packet_size};
      dtype = x.value_word[15:8];
      didx = x.value_word[7:0];
      if (x.ep_index == 4'd0) begin
         // decode priority: direction bit, then SETUP, then reception
         if (!x.dir_flag) r.transaction_kind = KIND_IN;
         else if (x.setup_flag) r.transaction_kind = KIND_SETUP;
         else if (x.rx_done_flag) r.transaction_kind = KIND_OUT;
         else r.error = 1'b1;

         if (r.error) begin
            // endpoint zero is left parked at nak
            r.ep0_rx_new = HS_NAK;
            r.ep0_tx_new = HS_NAK;
         end else if (r.transaction_kind == KIND_SETUP) begin
            ctl_stage = CS_SETUP;
            setup_value = x.value_word;
            r.ep0_rx_new = hs_type'(x.rx_status);
            r.ep0_tx_new = hs_type'(x.tx_status);
            if (x.length_word == 16'd0) begin
               if (x.request_code == ReqSetAddress || x.request_code == ReqSetConfig) begin
                  dev_stage = (x.request_code == ReqSetAddress) ? DS_ADDRESS : DS_CONFIGURE;
                  r.tx_count_write = 1'b1;
                  r.tx_count = 8'd0;
                  r.ep0_tx_new = HS_VALID;
               end
            end else if ((x.request_type & ReqTypeDeviceToHost) != 8'd0) begin
               if (x.request_code == ReqGetDescriptor) begin
                  if (dtype == DescDevice) begin
                     load_chunk(r, DeviceDescLength, LOAD_DEVICE);
                     ctl_stage = CS_LAST_DATA_IN;
                  end else if (dtype == DescConfig) begin
                     if (x.length_word == {8'd0, ConfigShortLength}) begin
                        load_chunk(r, ConfigShortLength, LOAD_CONFIG_SHORT);
                        ctl_stage = CS_LAST_DATA_IN;
                     end else if (x.length_word == {8'd0, regs.config_total_length}) begin
                        // whole descriptor fits in one chunk, or the first of two
                        if (regs.config_total_length <= ps8) begin
                           load_chunk(r, regs.config_total_length, LOAD_CONFIG_FIRST);
                           ctl_stage = CS_LAST_DATA_IN;
                        end else begin
                           load_chunk(r, ps8, LOAD_CONFIG_FIRST);
                           ctl_stage = CS_DATA_IN;
                        end
                     end else begin
                        stall_ep0(r);
                     end
                  end else if (dtype == DescString) begin
                     case (didx)
                        8'd0:    load_chunk(r, regs.langid_length, LOAD_LANGID);
                        8'd1:    load_chunk(r, regs.vendor_length, LOAD_VENDOR);
                        8'd2:    load_chunk(r, regs.product_length, LOAD_PRODUCT);
                        8'd3:    load_chunk(r, regs.serial_length, LOAD_SERIAL);
                        default: stall_ep0(r);
                     endcase
                     if (didx <= 8'd3) ctl_stage = CS_LAST_DATA_IN;
                  end else if (dtype != DescEndpoint) begin
                     stall_ep0(r);
                  end
               end
            end else if ((x.request_type & ClassMask) != 8'd0) begin
               if (x.request_code == ReqSetLineCoding) begin
                  stall_ep0(r);
                  r.rx_count_arm = 1'b1;
                  ctl_stage = CS_LAST_DATA_OUT;
                  dev_stage = DS_CONFIGURED;
               end
            end
         end else if (r.transaction_kind == KIND_OUT) begin
            r.ep0_rx_new = hs_type'(x.rx_status);
            r.ep0_tx_new = hs_type'(x.tx_status);
            if (ctl_stage == CS_LAST_DATA_OUT) begin
               r.ep0_rx_new = HS_STALL;
               r.ep0_tx_new = HS_VALID;
               r.tx_count_write = 1'b1;
               r.tx_count = 8'd0;
               ctl_stage = CS_STATUS_IN;
            end
         end else begin
            r.ep0_rx_new = HS_NAK;
            r.ep0_tx_new = HS_NAK;
            if (dev_stage == DS_ADDRESS) begin
               r.address_write = 1'b1;
               r.device_address = setup_value[6:0];
               r.rx_count_arm = 1'b1;
               dev_stage = DS_CONFIGURE;
               stall_ep0(r);
            end else if (ctl_stage == CS_LAST_DATA_IN) begin
               ctl_stage = CS_STATUS_OUT;
               stall_ep0(r);
            end else if (ctl_stage == CS_DATA_IN) begin
               r.tx_count_write = 1'b1;
               r.tx_count = (regs.config_total_length > ps8) ?
                            regs.config_total_length - ps8 : 8'd0;
               r.load_source = LOAD_CONFIG_REST;
               ctl_stage = CS_LAST_DATA_IN;
               r.ep0_rx_new = HS_VALID;
               r.ep0_tx_new = HS_VALID;
            end else if (ctl_stage == CS_STATUS_IN) begin
               stall_ep0(r);
            end
         end
      end else begin
         // other endpoints: only the kind, the error flag and the endpoint one re-arm mean anything
         if (x.rx_done_flag) r.transaction_kind = KIND_OUT;
         else if (x.tx_done_flag) r.transaction_kind = KIND_IN;
         else r.error = 1'b1;
         r.ep1_tx_arm = !r.error && r.transaction_kind == KIND_IN && x.ep_index == 4'd1;
      end
      return r;
   endfunction

   function automatic usb_xfer_type random_xfer();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(usb_xfer_type)-1:0];
   endfunction

   // Setup on endpoint zero; flags and prior handshakes that do not matter stay random
   function automatic usb_xfer_type setup_xfer(input logic [7:0] rtype, input logic [7:0] code,
                                               input logic [15:0] value,
                                               input logic [15:0] length);
      usb_xfer_type x;
      x = random_xfer();
      x.ep_index = 4'd0;
      x.dir_flag = 1'b1;
      x.setup_flag = 1'b1;
      x.request_type = rtype;
      x.request_code = code;
      x.value_word = value;
      x.length_word = length;
      return x;
   endfunction

   function automatic usb_xfer_type in_xfer();
      usb_xfer_type x;
      x = random_xfer();
      x.ep_index = 4'd0;
      x.dir_flag = 1'b0;
      return x;
   endfunction

   function automatic usb_xfer_type out_xfer();
      usb_xfer_type x;
      x = random_xfer();
      x.ep_index = 4'd0;
      x.dir_flag = 1'b1;
      x.setup_flag = 1'b0;
      x.rx_done_flag = 1'b1;
      return x;
   endfunction

   function automatic usb_xfer_type other_xfer(input logic [3:0] ep, input logic rxd,
                                               input logic txd);
      usb_xfer_type x;
      x = random_xfer();
      x.ep_index = ep;
      x.rx_done_flag = rxd;
      x.tx_done_flag = txd;
      return x;
   endfunction

   // Offer one transaction after a random gap and hold it until the block takes it.
   // Acceptance is decided at the falling edge, where valid and stall are settled.
   task automatic send_transfer(input usb_xfer_type x);
      int unsigned gap;
      gap = sender_idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ep_index <= x.ep_index;
      req_dir_flag <= x.dir_flag;
      req_setup_flag <= x.setup_flag;
      req_rx_done_flag <= x.rx_done_flag;
      req_tx_done_flag <= x.tx_done_flag;
      req_rx_status <= x.rx_status;
      req_tx_status <= x.tx_status;
      req_request_type <= x.request_type;
      req_request_code <= x.request_code;
      req_value_word <= x.value_word;
      req_length_word <= x.length_word;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      pending_responses.push_back(predict_response(x));
      sent_count++;
   endtask

   // Drop valid, drain every predicted response, then let the pipeline settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all six registers on consecutive edges; only called while idle
   task automatic apply_settings(input cfg_type s);
      csr_write <= 1'b1;
      csr_index <= CSR_PACKET_SIZE;
      csr_data <= {1'b0, s.packet_size};
      @(posedge clock);
      csr_index <= CSR_CONFIG_LENGTH;
      csr_data <= s.config_total_length;
      @(posedge clock);
      csr_index <= CSR_LANGID_LENGTH;
      csr_data <= s.langid_length;
      @(posedge clock);
      csr_index <= CSR_VENDOR_LENGTH;
      csr_data <= s.vendor_length;
      @(posedge clock);
      csr_index <= CSR_PRODUCT_LENGTH;
      csr_data <= s.product_length;
      @(posedge clock);
      csr_index <= CSR_SERIAL_LENGTH;
      csr_data <= s.serial_length;
      @(posedge clock);
      csr_write <= 1'b0;
      regs = s;
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= MaxReported)
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want_v, got_v);
      end
   endtask

   // Get-descriptor, then status, using the power-on register values
   task automatic test_descriptor_requests();
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescDevice, 8'd0}, 16'd18));
      send_transfer(in_xfer());
      send_transfer(out_xfer());
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0}, 16'd9));
      send_transfer(in_xfer());
      // default config length exceeds the packet size: two chunks
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0},
                               {8'd0, ConfigLengthReset}));
      send_transfer(in_xfer());
      send_transfer(in_xfer());
      for (int i = 0; i <= 4; i++)
         send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor,
                                  {DescString, 8'(i)}, 16'd255));
      send_transfer(setup_xfer(8'hFF, ReqGetDescriptor, 16'hFFFF, 16'hFFFF));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescEndpoint, 8'd0}, 16'd7));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0}, 16'd10));
   endtask

   // Address latches on the status IN; configuration request has no data stage
   task automatic test_address_and_configuration();
      send_transfer(setup_xfer(ReqTypeStandardOut, ReqSetAddress, 16'hFFFF, 16'd0));
      send_transfer(in_xfer());
      send_transfer(in_xfer());
      send_transfer(setup_xfer(ReqTypeStandardOut, ReqSetConfig, 16'h0001, 16'd0));
      send_transfer(in_xfer());
   endtask

   // Class OUT request: data OUT, then status IN
   task automatic test_line_coding();
      send_transfer(setup_xfer(ReqTypeClassIface, ReqSetLineCoding, 16'd0, 16'd7));
      send_transfer(out_xfer());
      send_transfer(in_xfer());
      // no class bits set: left unhandled
      send_transfer(setup_xfer(ReqTypeStandardOut, ReqSetLineCoding, 16'd0, 16'd7));
      send_transfer(out_xfer());
   endtask

   task automatic test_errors_and_other_endpoints();
      usb_xfer_type x;
      x = out_xfer();
      x.rx_done_flag = 1'b0;
      send_transfer(x);
      send_transfer(other_xfer(4'd1, 1'b0, 1'b1));
      send_transfer(other_xfer(4'd1, 1'b1, 1'b1));
      send_transfer(other_xfer(4'd15, 1'b0, 1'b0));
      send_transfer(other_xfer(4'd2, 1'b0, 1'b1));
   endtask

   // Smallest and largest length register values, including the whole-in-one-chunk case
   task automatic test_register_extremes();
      wait_for_idle();
      apply_settings(make_regs(7'd8, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0}, 16'd255));
      send_transfer(in_xfer());
      send_transfer(in_xfer());
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescString, 8'd2}, 16'd2));
      wait_for_idle();
      apply_settings(make_regs(7'd64, 8'd9, 8'd255, 8'd255, 8'd255, 8'd255));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0}, 16'd9));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescString, 8'd0}, 16'd4));
      send_transfer(in_xfer());
      wait_for_idle();
      apply_settings(make_regs(7'd64, 8'd64, 8'd1, 8'd2, 8'd3, 8'd4));
      send_transfer(setup_xfer(ReqTypeDeviceToHost, ReqGetDescriptor, {DescConfig, 8'd0}, 16'd64));
      send_transfer(in_xfer());
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering back to back
   task automatic test_input_backpressure();
      wait_for_idle();
      sender_idle_on = 1'b0;
      long_hold_request = 1'b1;
      repeat (20) send_transfer(random_xfer());
      sender_idle_on = 1'b1;
   endtask

   // One random control transfer, a request on another endpoint, or plain noise
   task automatic run_random_sequence();
      int unsigned  pick;
      logic [7:0]   dtype;
      logic [7:0]   didx;
      logic [7:0]   rtype;
      logic [15:0]  len;
      usb_xfer_type x;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         case ($urandom_range(0, 5))
            0:       dtype = DescDevice;
            1, 2:    dtype = DescConfig;
            3:       dtype = DescString;
            4:       dtype = DescEndpoint;
            default: dtype = 8'($urandom);
         endcase
         didx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         case ($urandom_range(0, 3))
            0:       len = {8'd0, ConfigShortLength};
            1, 2:    len = {8'd0, regs.config_total_length};
            default: len = 16'($urandom);
         endcase
         send_transfer(setup_xfer(ReqTypeDeviceToHost | 8'($urandom_range(0, 127)),
                                  ReqGetDescriptor, {dtype, didx}, len));
         repeat ($urandom_range(1, 3)) send_transfer(in_xfer());
         send_transfer(out_xfer());
      end else if (pick < 62) begin
         send_transfer(setup_xfer(8'($urandom), ReqSetAddress, 16'($urandom), 16'd0));
         repeat ($urandom_range(1, 2)) send_transfer(in_xfer());
      end else if (pick < 70) begin
         send_transfer(setup_xfer(8'($urandom), ReqSetConfig, 16'($urandom), 16'd0));
         send_transfer(in_xfer());
      end else if (pick < 80) begin
         rtype = {1'b0, 7'($urandom)} | (($urandom_range(0, 1) != 0) ? 8'h20 : 8'h01);
         send_transfer(setup_xfer(rtype, ReqSetLineCoding, 16'($urandom),
                                  16'($urandom_range(1, 65535))));
         repeat ($urandom_range(1, 2)) send_transfer(out_xfer());
         send_transfer(in_xfer());
      end else if (pick < 90) begin
         send_transfer(other_xfer(4'($urandom_range(1, 15)), 1'($urandom), 1'($urandom)));
      end else begin
         x = random_xfer();
         if ($urandom_range(0, 1) != 0) x.ep_index = 4'd0;
         send_transfer(x);
      end
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      logic [6:0]  ps;
      logic [7:0]  cl;
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         ps = 7'($urandom_range(8, 64));
         // keep the config length close to the packet size half the time
         cl = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(9, 255)) :
              8'(ps + $urandom_range(0, 20) - 10);
         if (cl < 8'd9) cl = 8'd9;
         if (phase == 3)
            apply_settings(make_regs(PacketSizeReset, ConfigLengthReset, LangidLengthReset,
                                     VendorLengthReset, ProductLengthReset, SerialLengthReset));
         else
            apply_settings(make_regs(ps, cl, 8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom)));
         start = sent_count;
         while (sent_count - start < ItemsPerPhase) begin
            // flip idling now and then so that runs of back-to-back traffic occur
            if ($urandom_range(0, 29) == 0) sender_idle_on = !sender_idle_on;
            if ($urandom_range(0, 29) == 0) receiver_idle_on = !receiver_idle_on;
            run_random_sequence();
         end
      end
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // Response side: draw a stall length per transaction, then take and check the result
   initial begin : response_checker
      int unsigned hold;
      rsp_type     want;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_request) begin
            hold = LongHold;
            long_hold_request = 1'b0;
         end else begin
            hold = receiver_idle_on ? $urandom_range(0, MaxIdle) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (rsp_valid !== 1'b1);
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
               $display("%0t ns: response expected none actual error=%0h kind=%0h", $time,
                        rsp_error, rsp_transaction_kind);
         end else begin
            want = pending_responses.pop_front();
            check_field("error", 16'(want.error), 16'(rsp_error));
            check_field("transaction_kind", 16'(want.transaction_kind),
                        16'(rsp_transaction_kind));
            check_field("ep0_rx_new", 16'(want.ep0_rx_new), 16'(rsp_ep0_rx_new));
            check_field("ep0_tx_new", 16'(want.ep0_tx_new), 16'(rsp_ep0_tx_new));
            check_field("tx_count_write", 16'(want.tx_count_write), 16'(rsp_tx_count_write));
            check_field("tx_count", 16'(want.tx_count), 16'(rsp_tx_count));
            check_field("load_source", 16'(want.load_source), 16'(rsp_load_source));
            check_field("rx_count_arm", 16'(want.rx_count_arm), 16'(rsp_rx_count_arm));
            check_field("address_write", 16'(want.address_write), 16'(rsp_address_write));
            check_field("device_address", 16'(want.device_address), 16'(rsp_device_address));
            check_field("ep1_tx_arm", 16'(want.ep1_tx_arm), 16'(rsp_ep1_tx_arm));
         end
         @(posedge clock);
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      // mirror the reset values of the block
      regs = make_regs(PacketSizeReset, ConfigLengthReset, LangidLengthReset,
                       VendorLengthReset, ProductLengthReset, SerialLengthReset);
      dev_stage = DS_DEFAULT;
      ctl_stage = CS_SETUP;
      setup_value = 16'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_descriptor_requests();
      test_address_and_configuration();
      test_line_coding();
      test_errors_and_other_endpoints();
      test_register_extremes();
      test_input_backpressure();
      test_random_traffic();

      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
